@@ sv/huffman_code_bit_packer_macros.svh @@
// assertion helpers for the bit packer checker
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// antecedent holds, consequent in the same cycle
`define HCBP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcbp check failed");

// antecedent holds, consequent in the next cycle
`define HCBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcbp check failed");

`endif

@@ sv/hcbp_pkg.sv @@
package hcbp_pkg;

  localparam int SYM_W            = 8;
  localparam int TABLE_DEPTH      = 256;
  localparam int CODE_W           = 32;
  localparam int LEN_W            = 6;
  localparam int REQ_W            = 2;
  localparam int BYTE_W           = 8;
  localparam int PEND_W           = BYTE_W - 1;
  localparam int CNT_W            = 3;
  localparam int MAX_CODE_LEN_DEF = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EMIT,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } tbl_entry_t;

  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] addr;
    tbl_entry_t       entry;
  } tbl_wr_t;

endpackage

@@ sv/hcbp_if.sv @@
interface hcbp_item_if;
  import hcbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] entry_code;
  logic [LEN_W-1:0]  entry_length;

  modport source (output valid, req_type, symbol, entry_code, entry_length, input ready);
  modport sink   (input valid, req_type, symbol, entry_code, entry_length, output ready);
endinterface

interface hcbp_result_if;
  import hcbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;

  modport source (output valid, out_byte, last_of_run, input ready);
  modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

@@ sv/huffman_code_bit_packer.sv @@
// Huffman code bit packer, one request at a time.
// load: table written on accept. flush: with bits pending, byte registered in the flush
// state once the output slot is free. encode: n output words (n up to (7 + MAX_CODE_LEN) / 8),
// after the code table read, at one word per cycle while the output is not stalled.
// Synchronous reset clears the pending bits and the table's written flags;
// the table is usable in the first cycle after reset.
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input logic          clk,
  input logic          rst,
  hcbp_item_if.sink    item,
  hcbp_result_if.source result
);
  import hcbp_pkg::*;

  localparam int ACC_W = PEND_W + MAX_CODE_LEN;
  localparam int TOT_W = $clog2(ACC_W + 1);

  state_t             state, state_next;
  logic [PEND_W-1:0]  pend;
  logic [CNT_W-1:0]   cnt;
  logic [ACC_W-1:0]   acc;
  logic [TOT_W-1:0]   total;
  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_last;

  tbl_wr_t            tbl_wr;
  tbl_entry_t         tbl_rd;
  logic               accept;
  logic               slot_free;
  logic               fire;
  logic [ACC_W-1:0]   code_m;
  logic [TOT_W-1:0]   tot_lk;
  logic [TOT_W-1:0]   shamt;
  logic [ACC_W-1:0]   acc_lk;
  logic [ACC_W-1:0]   acc_shift;
  logic [TOT_W-1:0]   rem;
  logic               rem_last;
  logic [LEN_W-1:0]   len_sat;

  hcbp_table u_table (
    .clk     (clk),
    .rst     (rst),
    .wr      (tbl_wr),
    .rd_en   (accept),
    .rd_addr (item.symbol),
    .rd_data (tbl_rd)
  );

  assign accept    = item.valid && item.ready;
  assign slot_free = !out_valid || result.ready;

  assign len_sat = (item.entry_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                              : item.entry_length;

  // new code goes right behind the pending bits, stream left aligned in acc
  assign code_m = ACC_W'(tbl_rd.code) & ~({ACC_W{1'b1}} << tbl_rd.len);
  assign tot_lk = TOT_W'(cnt) + TOT_W'(tbl_rd.len);
  assign shamt  = TOT_W'(ACC_W) - tot_lk;
  assign acc_lk = {pend, {MAX_CODE_LEN{1'b0}}} | (code_m << shamt);

  assign acc_shift = acc << BYTE_W;
  assign rem       = total - TOT_W'(BYTE_W);
  assign rem_last  = rem < TOT_W'(BYTE_W);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item.valid) begin
          case (item.req_type)
            REQ_ENCODE: state_next = S_LOOKUP;
            REQ_FLUSH:  state_next = (cnt != '0) ? S_FLUSH : S_IDLE;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_LOOKUP: state_next = (tot_lk >= TOT_W'(BYTE_W)) ? S_EMIT : S_IDLE;
      S_EMIT:   state_next = (slot_free && rem_last) ? S_IDLE : S_EMIT;
      S_FLUSH:  state_next = slot_free ? S_IDLE : S_FLUSH;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item.ready   = (state == S_IDLE);
    fire         = ((state == S_EMIT) || (state == S_FLUSH)) && slot_free;
    tbl_wr.en    = accept && (item.req_type == REQ_LOAD);
    tbl_wr.addr  = item.symbol;
    tbl_wr.entry = '{code: item.entry_code, len: len_sat};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pending bits are kept left aligned, unused low bits zero
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      cnt  <= '0;
    end else if (state == S_LOOKUP && tot_lk < TOT_W'(BYTE_W)) begin
      pend <= acc_lk[ACC_W-1 -: PEND_W];
      cnt  <= CNT_W'(tot_lk);
    end else if (state == S_EMIT && fire && rem_last) begin
      pend <= acc_shift[ACC_W-1 -: PEND_W];
      cnt  <= CNT_W'(rem);
    end else if (state == S_FLUSH && fire) begin
      pend <= '0;
      cnt  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOOKUP) begin
      acc   <= acc_lk;
      total <= tot_lk;
    end else if (state == S_EMIT && fire) begin
      acc   <= acc_shift;
      total <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (state == S_FLUSH) begin
        out_byte <= {pend, 1'b0};
        out_last <= 1'b1;
      end else begin
        out_byte <= acc[ACC_W-1 -: BYTE_W];
        out_last <= rem_last;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.out_byte    = out_byte;
  assign result.last_of_run = out_last;

endmodule

@@ sv/hcbp_table.sv @@
module hcbp_table (
  input  logic                         clk,
  input  logic                         rst,
  input  hcbp_pkg::tbl_wr_t            wr,
  input  logic                         rd_en,
  input  logic [hcbp_pkg::SYM_W-1:0]   rd_addr,
  output hcbp_pkg::tbl_entry_t         rd_data
);
  import hcbp_pkg::*;

  tbl_entry_t             mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] written;
  tbl_entry_t             rd_entry;
  logic                   rd_written;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

  // entries never loaded read back with zero length
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  always_comb begin
    rd_data.code = rd_entry.code;
    rd_data.len  = rd_written ? rd_entry.len : '0;
  end

endmodule

@@ sv/hcbp_checker.sv @@
`include "huffman_code_bit_packer_macros.svh"

module hcbp_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_ready,
  input logic [hcbp_pkg::REQ_W-1:0] item_req_type,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [hcbp_pkg::BYTE_W-1:0] result_out_byte,
  input logic                       result_last_of_run
);
  import hcbp_pkg::*;

  // a stalled word holds
  `HCBP_ASSERT_NEXT(a_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result_out_byte) && $stable(result_last_of_run))

  // an encode keeps the block busy in the next cycle for the table read
  `HCBP_ASSERT_NEXT(a_encode_busy, clk, rst, item_valid && item_ready && item_req_type == REQ_ENCODE, !item_ready)

  // new words only come out of the emit or flush states
  `HCBP_ASSERT_NOW(a_word_source, clk, rst, $rose(result_valid), !$past(item_ready))

  // output register empty after reset
  `HCBP_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !result_valid)

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
  .clk                (clk),
  .rst                (rst),
  .item_valid         (item.valid),
  .item_ready         (item.ready),
  .item_req_type      (item.req_type),
  .result_valid       (result.valid),
  .result_ready       (result.ready),
  .result_out_byte    (result.out_byte),
  .result_last_of_run (result.last_of_run)
);

@@ tb/sv/bit_packer_checker.sv @@
`timescale 1ns / 100ps

module bit_packer_checker #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input logic    clk,
  input logic    rst,
  hcbp_item_if   item_mon,
  hcbp_result_if result_mon,
  output int     fail_count,
  output int     words_due
);
  import hcbp_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_val;
    logic              last;
  } packed_word_t;

  logic [CODE_W-1:0] code_tbl [TABLE_DEPTH];
  logic [LEN_W-1:0]  len_tbl  [TABLE_DEPTH];
  logic [PEND_W-1:0] held_bits;
  logic [CNT_W-1:0]  held_count;
  packed_word_t      expected_words [$];

  initial begin
    fail_count = 0;
    words_due  = 0;
    held_bits  = '0;
    held_count = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      code_tbl[i] = '0;
      len_tbl[i]  = '0;
    end
  end

  // works out the words one accepted request gives and updates the packer state
  function automatic void pack_request(input logic [REQ_W-1:0] kind,
                                       input logic [SYM_W-1:0] sym,
                                       input logic [CODE_W-1:0] code,
                                       input logic [LEN_W-1:0] len);
    logic [63:0]       stream;
    logic [63:0]       masked;
    logic [BYTE_W-1:0] flushed;
    packed_word_t      w;
    int unsigned       bits;
    int unsigned       n;
    int unsigned       code_len;
    case (kind)
      REQ_LOAD: begin
        code_tbl[sym] = code;
        len_tbl[sym]  = (len > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : len;
      end
      REQ_ENCODE: begin
        code_len = len_tbl[sym];
        if (code_len != 0) begin
          masked = 64'(code_tbl[sym]) & ((64'd1 << code_len) - 64'd1);
          stream = (64'(held_bits) << code_len) | masked;
          bits   = int'(held_count) + code_len;
          n      = bits / BYTE_W;
          for (int i = 0; i < n; i++) begin
            bits       = bits - BYTE_W;
            w.byte_val = BYTE_W'(stream >> bits);
            w.last     = (i == n - 1);
            expected_words.push_back(w);
          end
          held_bits  = PEND_W'(stream & ((64'd1 << bits) - 64'd1));
          held_count = CNT_W'(bits);
        end
      end
      REQ_FLUSH: begin
        if (held_count != 0) begin
          flushed    = {1'b0, held_bits};
          flushed    = flushed << (BYTE_W - int'(held_count));
          w.byte_val = flushed;
          w.last     = 1'b1;
          expected_words.push_back(w);
          held_bits  = '0;
          held_count = '0;
        end
      end
      default: ;  // unknown request: nothing changes
    endcase
  endfunction

  always @(posedge clk) begin
    packed_word_t want;
    if (rst) begin
      expected_words.delete();
      held_bits  = '0;
      held_count = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) len_tbl[i] = '0;
    end else begin
      // the block serves one request at a time, so a word taken on this edge
      // belongs to an earlier request than one accepted on the same edge
      if (result_mon.valid && result_mon.ready) begin
        if (expected_words.size() == 0) begin
          $error("word %h (last %b) with nothing expected",
                 result_mon.out_byte, result_mon.last_of_run);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (result_mon.out_byte !== want.byte_val) begin
            $error("out_byte: expected %h, actual %h", want.byte_val, result_mon.out_byte);
            fail_count++;
          end
          if (result_mon.last_of_run !== want.last) begin
            $error("last_of_run: expected %b, actual %b", want.last,
                   result_mon.last_of_run);
            fail_count++;
          end
        end
      end
      if (item_mon.valid && item_mon.ready)
        pack_request(item_mon.req_type, item_mon.symbol, item_mon.entry_code,
                     item_mon.entry_length);
    end
    words_due = expected_words.size();
  end

endmodule

@@ tb/sv/huffman_code_bit_packer_test.sv @@
`timescale 1ns / 100ps

module huffman_code_bit_packer_test;
  import hcbp_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 600000;

  logic clk;
  logic rst;
  int   fail_count;
  int   words_due;
  int   items_taken;
  int   cycle_count;
  bit   quiet_sender;
  bit   quiet_receiver;
  bit   loaded [TABLE_DEPTH];
  logic [SYM_W-1:0] loaded_syms [$];

  hcbp_item_if   item_ch ();
  hcbp_result_if result_ch ();

  huffman_code_bit_packer #(.MAX_CODE_LEN(MAX_CODE_LEN_DEF)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch.sink),
    .result (result_ch.source)
  );

  bit_packer_checker #(.MAX_CODE_LEN(MAX_CODE_LEN_DEF)) checker_i (
    .clk        (clk),
    .rst        (rst),
    .item_mon   (item_ch),
    .result_mon (result_ch),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    items_taken = 0;
    cycle_count = 0;
  end

  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready) items_taken <= items_taken + 1;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 65) return LEN_W'($urandom_range(1, 8));
    if (r < 88) return LEN_W'($urandom_range(9, 20));
    if (r < 96) return LEN_W'($urandom_range(21, 32));
    return LEN_W'($urandom_range(33, 63));  // saturated by the block
  endfunction

  // receiver: random stalls, with quiet stretches of full rate
  initial begin
    int unsigned stall;
    int unsigned phase;
    stall = 0;
    phase = 0;
    result_ch.ready = 1'b0;
    quiet_receiver  = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      phase++;
      if (phase % 300 == 0) quiet_receiver = ($urandom_range(0, 3) == 0);
      if (stall > 0) begin
        result_ch.ready = 1'b0;
        stall--;
      end else begin
        result_ch.ready = 1'b1;
        if (!quiet_receiver && $urandom_range(0, 99) < 30) stall = idle_cycles();
      end
    end
  end

  task automatic offer_item(input logic [REQ_W-1:0] kind, input logic [SYM_W-1:0] sym,
                            input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
    int unsigned gap;
    int seen;
    gap = quiet_sender ? 0 : idle_cycles();
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid        = 1'b1;
    item_ch.req_type     = kind;
    item_ch.symbol       = sym;
    item_ch.entry_code   = code;
    item_ch.entry_length = len;
    seen = items_taken;
    do @(negedge clk); while (items_taken == seen);
    if (kind == REQ_LOAD && !loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  task automatic wait_drained();
    item_ch.valid = 1'b0;
    while (words_due != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned r;
    logic [SYM_W-1:0] sym;
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.req_type     = REQ_LOAD;
    item_ch.symbol       = '0;
    item_ch.entry_code   = '0;
    item_ch.entry_length = '0;
    quiet_sender         = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) loaded[i] = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // directed: table extremes, saturation, zero length, flush corners
    offer_item(REQ_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
    offer_item(REQ_LOAD, 8'hFF, 32'h0000_0000, 6'd1);
    offer_item(REQ_LOAD, 8'h5A, 32'h0000_00A5, 6'd8);
    offer_item(REQ_LOAD, 8'h01, 32'h1234_5678, 6'd63);
    offer_item(REQ_LOAD, 8'h02, 32'hFFFF_FFFF, 6'd3);
    offer_item(REQ_LOAD, 8'h03, 32'hDEAD_BEEF, 6'd0);
    offer_item(REQ_FLUSH, 8'h00, '0, '0);
    offer_item(REQ_ENCODE, 8'h03, '0, '0);
    offer_item(REQ_ENCODE, 8'hFF, '0, '0);
    offer_item(REQ_FLUSH, 8'h00, '0, '0);
    offer_item(REQ_ENCODE, 8'h00, '0, '0);
    offer_item(REQ_ENCODE, 8'hFF, '0, '0);
    offer_item(REQ_ENCODE, 8'h00, '0, '0);
    offer_item(REQ_ENCODE, 8'h01, '0, '0);
    offer_item(REQ_ENCODE, 8'h02, '0, '0);
    offer_item(REQ_ENCODE, 8'hFF, '0, '0);
    offer_item(REQ_ENCODE, 8'hFF, '0, '0);
    offer_item(REQ_ENCODE, 8'hFF, '0, '0);
    // seven bits pending plus a full-length code gives four words
    offer_item(REQ_ENCODE, 8'h00, '0, '0);
    offer_item(REQ_FLUSH, 8'h00, '0, '0);
    offer_item(REQ_ENCODE, 8'h5A, '0, '0);
    offer_item(REQ_UNUSED, 8'hC3, 32'h8000_0001, 6'd33);
    offer_item(REQ_ENCODE, 8'h02, '0, '0);
    offer_item(REQ_FLUSH, 8'h00, '0, '0);
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) quiet_sender = ($urandom_range(0, 3) == 0);
      if (n % 130 == 129) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 15 || (r < 85 && loaded_syms.size() == 0)) begin
        offer_item(REQ_LOAD, SYM_W'($urandom_range(0, 255)), $urandom(), pick_length());
      end else if (r < 85) begin
        // only written entries are ever looked up
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        offer_item(REQ_ENCODE, sym, $urandom(), LEN_W'($urandom_range(0, 63)));
      end else if (r < 97) begin
        offer_item(REQ_FLUSH, SYM_W'($urandom_range(0, 255)), $urandom(),
                   LEN_W'($urandom_range(0, 63)));
      end else begin
        offer_item(REQ_UNUSED, SYM_W'($urandom_range(0, 255)), $urandom(),
                   LEN_W'($urandom_range(0, 63)));
      end
    end
    offer_item(REQ_FLUSH, 8'h00, '0, '0);
    wait_drained();
    repeat (20) @(negedge clk);

    if (fail_count == 0 && words_due == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
